// File: rtl/mqtt_receive_deframer_assert.svh
// ----------------------------------------------------------------------------
// MQTT receive deframer assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MQTT_RECEIVE_DEFRAMER_ASSERT_SVH
`define MQTT_RECEIVE_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define MQTTRD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mqttrd assertion failed");

// Next-cycle implication.
`define MQTTRD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mqttrd assertion failed");

`endif

// File: rtl/mqttrd_pkg.sv
// ----------------------------------------------------------------------------
// MQTT receive deframer package
// Result record and fixed codes shared by the parser and the top level.
// ----------------------------------------------------------------------------
package mqttrd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_TOPIC   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Packet type nibbles of interest
   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH = 4'd3;

   localparam int BODY_W  = 28;
   localparam int TOPIC_W = 16;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       part_last;
      logic       packet_last;
      logic       connack_ok;
      logic       send_subscribe;
   } result_type;

endpackage

// File: rtl/mqttrd_parser.sv
// ----------------------------------------------------------------------------
// MQTT receive deframer parser
// Holds parse and session state; advances one byte per step and forms
// at most one result for it.
// ----------------------------------------------------------------------------
`include "mqtt_receive_deframer_assert.svh"

module mqttrd_parser #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   req_type,
   input  logic [7:0]             rx_byte,
   output logic                   res_valid,
   output mqttrd_pkg::result_type res
);
   import mqttrd_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_LENGTH   = 3'd1,
      PH_SKIP     = 3'd2,
      PH_CONNACK  = 3'd3,
      PH_TOPICLEN = 3'd4,
      PH_TOPIC    = 3'd5,
      PH_PAYLOAD  = 3'd6
   } phase_type;

   localparam logic [2:0] MAX_GROUPS = 3'(MAX_LENGTH_BYTES);

   phase_type            phase_ff, phase_in;
   logic [3:0]           pkind_ff, pkind_in;
   logic [BODY_W-1:0]    body_ff, body_in;
   logic [1:0]           grp_ff, grp_in;
   logic [TOPIC_W-1:0]   topic_ff, topic_in;
   logic [1:0]           bidx_ff, bidx_in;
   logic                 rcz_ff, rcz_in;
   logic                 subdone_ff, subdone_in;

   logic [BODY_W-1:0]    grp_bits;
   logic [BODY_W-1:0]    body_or;
   logic [BODY_W-1:0]    body_dec;
   logic [TOPIC_W-1:0]   topic_dec;
   logic [TOPIC_W-1:0]   topic_new;
   logic                 do_verdict;
   logic                 verdict_ok;
   logic                 verdict_sub;
   logic                 res_error;
   logic                 res_sub;

   // Place the 7-bit length group at its weight
   always_comb begin
      case (grp_ff)
         2'd0:    grp_bits = {21'd0, rx_byte[6:0]};
         2'd1:    grp_bits = {14'd0, rx_byte[6:0], 7'd0};
         2'd2:    grp_bits = {7'd0, rx_byte[6:0], 14'd0};
         default: grp_bits = {rx_byte[6:0], 21'd0};
      endcase
   end

   assign body_or   = body_ff | grp_bits;
   assign body_dec  = body_ff - BODY_W'(1);
   assign topic_dec = topic_ff - TOPIC_W'(1);
   assign topic_new = topic_ff | {8'd0, rx_byte};

   always_comb begin
      phase_in    = phase_ff;
      pkind_in    = pkind_ff;
      body_in     = body_ff;
      grp_in      = grp_ff;
      topic_in    = topic_ff;
      bidx_in     = bidx_ff;
      rcz_in      = rcz_ff;
      subdone_in  = subdone_ff;
      res_valid   = 1'b0;
      res         = '0;
      do_verdict  = 1'b0;
      verdict_ok  = 1'b0;
      verdict_sub = 1'b0;

      if (step_en && req_type) begin
         // Link restart: clear parse and session state
         phase_in   = PH_HEADER;
         pkind_in   = '0;
         body_in    = '0;
         grp_in     = '0;
         topic_in   = '0;
         bidx_in    = '0;
         rcz_in     = 1'b0;
         subdone_in = 1'b0;
      end else if (step_en) begin
         case (phase_ff)
            PH_LENGTH: begin
               if (rx_byte[7]) begin
                  if (({1'b0, grp_ff} + 3'd1) >= MAX_GROUPS) begin
                     phase_in        = PH_HEADER;
                     grp_in          = '0;
                     body_in         = '0;
                     res_valid       = 1'b1;
                     res.kind        = KIND_ERROR;
                     res.packet_last = 1'b1;
                  end else begin
                     grp_in  = grp_ff + 2'd1;
                     body_in = body_or;
                  end
               end else begin
                  body_in  = body_or;
                  bidx_in  = '0;
                  rcz_in   = 1'b0;
                  topic_in = '0;
                  if (pkind_ff == TYPE_CONNACK) begin
                     if (body_or == '0) begin
                        phase_in   = PH_HEADER;
                        do_verdict = 1'b1;
                     end else begin
                        phase_in = PH_CONNACK;
                     end
                  end else if (pkind_ff == TYPE_PUBLISH) begin
                     if (body_or == '0) begin
                        phase_in = PH_HEADER;
                     end else if (body_or < BODY_W'(3)) begin
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_TOPICLEN;
                     end
                  end else begin
                     phase_in = (body_or == '0) ? PH_HEADER : PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               body_in = body_dec;
               if (body_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_CONNACK: begin
               if (bidx_ff == 2'd1) begin
                  rcz_in = (rx_byte == 8'd0);
               end
               if (bidx_ff < 2'd2) begin
                  bidx_in = bidx_ff + 2'd1;
               end
               body_in = body_dec;
               if (body_dec == '0) begin
                  phase_in   = PH_HEADER;
                  do_verdict = 1'b1;
                  verdict_ok = (bidx_in >= 2'd2) && rcz_in;
               end
            end
            PH_TOPICLEN: begin
               body_in = body_dec;
               if (bidx_ff == 2'd0) begin
                  topic_in = {rx_byte, 8'd0};
                  bidx_in  = 2'd1;
               end else begin
                  bidx_in  = 2'd2;
                  topic_in = topic_new;
                  if ((topic_new == '0) || ({12'd0, topic_new} > body_dec)) begin
                     phase_in = (body_dec == '0) ? PH_HEADER : PH_SKIP;
                  end else begin
                     phase_in = PH_TOPIC;
                  end
               end
            end
            PH_TOPIC: begin
               topic_in = topic_dec;
               body_in  = body_dec;
               if (topic_dec == '0) begin
                  phase_in = (body_dec == '0) ? PH_HEADER : PH_PAYLOAD;
               end
               res_valid       = 1'b1;
               res.kind        = KIND_TOPIC;
               res.data        = rx_byte;
               res.part_last   = (topic_dec == '0);
               res.packet_last = (body_dec == '0);
            end
            PH_PAYLOAD: begin
               body_in = body_dec;
               if (body_dec == '0) begin
                  phase_in = PH_HEADER;
               end
               res_valid       = 1'b1;
               res.kind        = KIND_PAYLOAD;
               res.data        = rx_byte;
               res.part_last   = (body_dec == '0);
               res.packet_last = (body_dec == '0);
            end
            default: begin
               // Header byte, or an unused phase code
               pkind_in = rx_byte[7:4];
               body_in  = '0;
               grp_in   = '0;
               phase_in = PH_LENGTH;
            end
         endcase

         if (do_verdict) begin
            verdict_sub        = verdict_ok && !subdone_ff;
            subdone_in         = subdone_ff | verdict_sub;
            res_valid          = 1'b1;
            res.kind           = KIND_VERDICT;
            res.packet_last    = 1'b1;
            res.connack_ok     = verdict_ok;
            res.send_subscribe = verdict_sub;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         pkind_ff   <= '0;
         body_ff    <= '0;
         grp_ff     <= '0;
         topic_ff   <= '0;
         bidx_ff    <= '0;
         rcz_ff     <= 1'b0;
         subdone_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pkind_ff   <= pkind_in;
         body_ff    <= body_in;
         grp_ff     <= grp_in;
         topic_ff   <= topic_in;
         bidx_ff    <= bidx_in;
         rcz_ff     <= rcz_in;
         subdone_ff <= subdone_in;
      end
   end

   assign res_error = step_en && res_valid && (res.kind == KIND_ERROR);
   assign res_sub   = step_en && res_valid && res.send_subscribe;

   `MQTTRD_ASSERT_NEXT(a_error_resync, res_error, phase_ff == PH_HEADER)
   `MQTTRD_ASSERT_NEXT(a_subscribe_once, res_sub, subdone_ff)
   `MQTTRD_ASSERT_NOW(a_sub_needs_fresh, res_sub, !subdone_ff)

endmodule

// File: rtl/mqtt_receive_deframer.sv
// ----------------------------------------------------------------------------
// MQTT receive deframer: one byte in per cycle while the result side does not stall.
// An input register feeds the parser; its result lands in a result register.
// Reset (synchronous, high) clears both valids and all parse/session state.
// ----------------------------------------------------------------------------
`include "mqtt_receive_deframer_assert.svh"

module mqtt_receive_deframer #(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_rx_byte,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_part_last,
   output logic       rsp_packet_last,
   output logic       rsp_connack_ok,
   output logic       rsp_send_subscribe
);
   import mqttrd_pkg::*;

   // Input register stage
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_type_ff;
   logic [7:0] s1_byte_ff;

   // Result register stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       out_ready;
   logic       step;
   logic       accept;
   logic       res_valid;
   result_type res;
   logic       rsp_closing;
   logic       rsp_sub;

   // The result register can take a new value when empty or when its
   // transfer completes this cycle.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   // Advance the held byte through the parser whenever the result side
   // can absorb what it produces.
   assign step      = s1_valid_ff && out_ready;
   // Hold the input side only when a byte waits and cannot advance.
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   mqttrd_parser #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step),
      .req_type (s1_type_ff),
      .rx_byte  (s1_byte_ff),
      .res_valid(res_valid),
      .res      (res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         // Bytes that cause no result leave the result register empty
         rsp_valid_in = step && res_valid;
         if (step && res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff <= req_type;
         s1_byte_ff <= req_rx_byte;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_data           = rsp_ff.data;
   assign rsp_part_last      = rsp_ff.part_last;
   assign rsp_packet_last    = rsp_ff.packet_last;
   assign rsp_connack_ok     = rsp_ff.connack_ok;
   assign rsp_send_subscribe = rsp_ff.send_subscribe;

   // Verdicts and framing errors close their packet
   assign rsp_closing = rsp_valid_ff &&
                        ((rsp_ff.kind == KIND_VERDICT) || (rsp_ff.kind == KIND_ERROR));
   assign rsp_sub     = rsp_valid_ff && rsp_ff.send_subscribe;

   `MQTTRD_ASSERT_NOW(a_stall_cause, req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall)
   `MQTTRD_ASSERT_NOW(a_single_last, rsp_closing, rsp_ff.packet_last && (rsp_ff.data == 8'd0))
   `MQTTRD_ASSERT_NOW(a_sub_is_verdict, rsp_sub, rsp_ff.connack_ok && (rsp_ff.kind == KIND_VERDICT))

endmodule

// File: tb/mqtt_receive_deframer_tb.sv
// ----------------------------------------------------------------------------
// MQTT receive deframer testbench
// Streams broker bytes into the deframer and checks every topic byte, payload
// byte, connack verdict and framing error against a cycle-free model of the
// parser kept alongside. Covers directed corner packets, then a random mix of
// well-formed and broken packets under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqtt_receive_deframer_tb;
   import mqttrd_pkg::*;

   localparam int LEN_GROUPS   = 4;       // length groups before a framing error
   localparam int CYCLE_LIMIT  = 400000;  // generous ceiling on the whole run
   localparam int DRAIN_CYCLES = 20;      // quiet cycles after the last result
   localparam int HOLD_AT      = 150;     // results seen before the long hold-off
   localparam int HOLD_CYCLES  = 300;     // length of the long hold-off

   // Request types on the input channel
   localparam logic REQ_BYTE    = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   // Parser phases of the model
   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_LENGTH   = 3'd1,
      PH_SKIP     = 3'd2,
      PH_CONNACK  = 3'd3,
      PH_TOPICLEN = 3'd4,
      PH_TOPIC    = 3'd5,
      PH_PAYLOAD  = 3'd6
   } phase_type;

   // One item for the input channel
   typedef struct packed {
      logic       restart;
      logic [7:0] rx;
   } rx_item_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // Block ports; every input starts at a known value
   logic       req_valid   = 1'b0;
   logic       req_type    = REQ_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_part_last;
   logic       rsp_packet_last;
   logic       rsp_connack_ok;
   logic       rsp_send_subscribe;

   mqtt_receive_deframer #(
      .MAX_LENGTH_BYTES(LEN_GROUPS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data           (rsp_data),
      .rsp_part_last      (rsp_part_last),
      .rsp_packet_last    (rsp_packet_last),
      .rsp_connack_ok     (rsp_connack_ok),
      .rsp_send_subscribe (rsp_send_subscribe)
   );

   // Bytes waiting to be sent, and deframed results waiting to come out
   rx_item_type rx_backlog[$];
   result_type  deframed_results[$];

   // Traffic shaping, set by the sequence process
   int send_idle_pct = 22;
   int recv_idle_pct = 74;

   // Bookkeeping
   int  bytes_queued   = 0;
   int  bytes_sent     = 0;
   int  restarts_sent  = 0;
   int  results_seen   = 0;
   int  kind_count[4]  = '{0, 0, 0, 0};
   int  subscribe_seen = 0;
   int  mismatches     = 0;
   int  cycle_count    = 0;
   bit  req_taken      = 1'b0;
   int  hold_left      = 0;
   bit  hold_done      = 1'b0;

   // ------------------------------------------------------------------------
   // Parser model state
   // ------------------------------------------------------------------------
   phase_type   ph;
   logic [3:0]  pkt_type;
   logic [27:0] body_left;
   logic [1:0]  group_idx;
   logic [15:0] topic_left;
   logic [1:0]  seen;
   logic        rc_zero;
   logic        sub_done;

   // Return every piece of parse and session state to its reset value.
   task automatic clear_session();
      ph         = PH_HEADER;
      pkt_type   = 4'h0;
      body_left  = 28'h0;
      group_idx  = 2'd0;
      topic_left = 16'h0;
      seen       = 2'd0;
      rc_zero    = 1'b0;
      sub_done   = 1'b0;
   endtask

   task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic part_last, input logic packet_last,
                              input logic ok, input logic sub);
      result_type r;
      r.kind           = kind;
      r.data           = data;
      r.part_last      = part_last;
      r.packet_last    = packet_last;
      r.connack_ok     = ok;
      r.send_subscribe = sub;
      deframed_results.push_back(r);
   endtask

   // Connack verdict; the subscribe request goes out once per session.
   task automatic give_verdict(input logic ok);
      logic sub;
      sub        = ok && !sub_done;
      if (sub) sub_done = 1'b1;
      push_result(KIND_VERDICT, 8'h00, 1'b0, 1'b1, ok, sub);
   endtask

   // Advance the parser model by one accepted transfer.
   task automatic deframe_byte(input logic restart, input logic [7:0] b);
      logic [27:0] len;
      if (restart == REQ_RESTART) begin
         clear_session();
         return;
      end
      case (ph)
         PH_LENGTH: begin
            body_left = body_left | (28'(b[6:0]) << (7 * group_idx));
            if (b[7]) begin
               // Continuation on the last allowed group: resynchronize.
               if (int'(group_idx) + 1 >= LEN_GROUPS) begin
                  ph        = PH_HEADER;
                  group_idx = 2'd0;
                  body_left = 28'h0;
                  push_result(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
               end else begin
                  group_idx = group_idx + 2'd1;
               end
            end else begin
               len        = body_left;
               seen       = 2'd0;
               rc_zero    = 1'b0;
               topic_left = 16'h0;
               if (pkt_type == TYPE_CONNACK) begin
                  if (len == 0) begin
                     ph = PH_HEADER;
                     give_verdict(1'b0);
                  end else begin
                     ph = PH_CONNACK;
                  end
               end else if (pkt_type == TYPE_PUBLISH) begin
                  if (len == 0)     ph = PH_HEADER;
                  else if (len < 3) ph = PH_SKIP;
                  else              ph = PH_TOPICLEN;
               end else begin
                  ph = (len == 0) ? PH_HEADER : PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            body_left = body_left - 28'd1;
            if (body_left == 0) ph = PH_HEADER;
         end
         PH_CONNACK: begin
            if (seen == 2'd1) rc_zero = (b == 8'h00);
            if (seen < 2'd2) seen = seen + 2'd1;
            body_left = body_left - 28'd1;
            if (body_left == 0) begin
               ph = PH_HEADER;
               give_verdict(seen >= 2'd2 && rc_zero);
            end
         end
         PH_TOPICLEN: begin
            body_left = body_left - 28'd1;
            if (seen == 2'd0) begin
               topic_left = {b, 8'h00};
               seen       = 2'd1;
            end else begin
               seen       = 2'd2;
               topic_left = topic_left | {8'h00, b};
               if (topic_left == 0 || {12'h000, topic_left} > body_left)
                  ph = (body_left == 0) ? PH_HEADER : PH_SKIP;
               else
                  ph = PH_TOPIC;
            end
         end
         PH_TOPIC: begin
            topic_left = topic_left - 16'd1;
            body_left  = body_left - 28'd1;
            if (topic_left == 0) ph = (body_left == 0) ? PH_HEADER : PH_PAYLOAD;
            push_result(KIND_TOPIC, b, topic_left == 0, body_left == 0, 1'b0, 1'b0);
         end
         PH_PAYLOAD: begin
            body_left = body_left - 28'd1;
            if (body_left == 0) ph = PH_HEADER;
            push_result(KIND_PAYLOAD, b, body_left == 0, body_left == 0, 1'b0, 1'b0);
         end
         default: begin
            pkt_type  = b[7:4];
            body_left = 28'h0;
            group_idx = 2'd0;
            ph        = PH_LENGTH;
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Packet builders: append bytes to the backlog
   // ------------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] b);
      rx_backlog.push_back({REQ_BYTE, b});
      bytes_queued++;
   endtask

   task automatic add_restart();
      rx_backlog.push_back({REQ_RESTART, 8'($urandom)});
      bytes_queued++;
   endtask

   // Remaining length, least significant group first. Now and then pad the
   // field with zero groups, which is legal but not minimal.
   task automatic add_length(input int len);
      int         v;
      int         groups;
      int         pad_to;
      logic       more;
      logic [6:0] grp;
      v      = len;
      groups = 0;
      pad_to = ($urandom_range(7) == 0) ? $urandom_range(LEN_GROUPS, 2) : 1;
      do begin
         grp    = v[6:0];
         v      = v >> 7;
         groups++;
         more   = (v != 0) || (groups < pad_to);
         add_byte({more, grp});
      end while (more);
   endtask

   // Header, length and a random body.
   task automatic add_packet(input logic [7:0] header, input int len);
      add_byte(header);
      add_length(len);
      repeat (len) add_byte(8'($urandom));
   endtask

   // Publish with a given topic length field and rest-of-body size.
   task automatic add_publish(input logic [15:0] tlen, input int rest);
      add_byte({TYPE_PUBLISH, 4'($urandom)});
      add_length(rest + 2);
      add_byte(tlen[15:8]);
      add_byte(tlen[7:0]);
      repeat (rest) add_byte(8'($urandom));
   endtask

   task automatic add_connack(input int len, input logic rc_ok);
      add_byte({TYPE_CONNACK, 4'($urandom)});
      add_length(len);
      for (int i = 0; i < len; i++)
         add_byte((i == 1 && rc_ok) ? 8'h00 : 8'($urandom));
   endtask

   // Every length group carries a continuation bit.
   task automatic add_unterminated();
      add_byte(8'($urandom));
      repeat (LEN_GROUPS) add_byte(8'h80 | 8'($urandom));
   endtask

   // Mostly well-formed packets with random content, the rest broken ones.
   task automatic add_random_traffic(input int count);
      int         stop_at;
      int         pick;
      int         tlen;
      int         plen;
      int         rest;
      logic [3:0] other;
      stop_at = bytes_queued + count;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            tlen = $urandom_range(6, 1);
            plen = ($urandom_range(39) == 0) ? $urandom_range(200, 120)
                                             : $urandom_range(10, 0);
            add_publish(16'(tlen), tlen + plen);
         end else if (pick < 60) begin
            add_connack(($urandom_range(3) == 0) ? $urandom_range(4, 0) : 2,
                        $urandom_range(2) != 0);
         end else if (pick < 70) begin
            other = 4'($urandom);
            if (other == TYPE_CONNACK || other == TYPE_PUBLISH) other = other + 4'd10;
            add_packet({other, 4'($urandom)}, $urandom_range(6, 0));
         end else if (pick < 76) begin
            // short publish body
            add_packet({TYPE_PUBLISH, 4'($urandom)}, $urandom_range(2, 1));
         end else if (pick < 80) begin
            // zero topic length
            add_publish(16'h0000, $urandom_range(5, 1));
         end else if (pick < 85) begin
            // topic length beyond the body
            rest = $urandom_range(5, 1);
            tlen = ($urandom_range(3) == 0) ? $urandom_range(65535, rest + 1) : rest + 1;
            add_publish(16'(tlen), rest);
         end else if (pick < 89) begin
            add_unterminated();
         end else if (pick < 93) begin
            // largest remaining length, cut short by a link restart
            add_byte({($urandom_range(1) != 0) ? TYPE_PUBLISH : 4'($urandom),
                      4'($urandom)});
            add_byte(8'hFF);
            add_byte(8'hFF);
            add_byte(8'hFF);
            add_byte(8'h7F);
            repeat ($urandom_range(8, 2)) add_byte(8'($urandom));
            add_restart();
         end else if (pick < 96) begin
            // line noise, then resynchronize with a restart
            repeat ($urandom_range(6, 1)) add_byte(8'($urandom));
            add_restart();
         end else begin
            add_restart();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report($sformatf("result %0d %s got %0h expected %0h",
                          results_seen, name, got, want));
   endtask

   task automatic check_result(input result_type got);
      result_type want;
      if (deframed_results.size() == 0) begin
         report($sformatf("result %0d kind %0d arrived with nothing outstanding",
                          results_seen, got.kind));
         return;
      end
      want = deframed_results.pop_front();
      check_field("kind",           8'(got.kind),           8'(want.kind));
      check_field("data",           got.data,               want.data);
      check_field("part_last",      8'(got.part_last),      8'(want.part_last));
      check_field("packet_last",    8'(got.packet_last),    8'(want.packet_last));
      check_field("connack_ok",     8'(got.connack_ok),     8'(want.connack_ok));
      check_field("send_subscribe", 8'(got.send_subscribe), 8'(want.send_subscribe));
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the oldest backlog byte at the falling edge and hold it
   // until the transfer completes. Idle between transfers at random.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_type    <= rx_backlog[0].restart;
            req_rx_byte <= rx_backlog[0].rx;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall at random; once, hold off for a long stretch so the
   // block fills up and pushes back on its input.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: on each rising edge, run accepted input transfers through the
   // model and compare accepted result transfers with the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            deframe_byte(req_type, req_rx_byte);
            if (req_type == REQ_RESTART) restarts_sent++;
            rx_backlog.pop_front();
            bytes_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind           = rsp_kind;
            got.data           = rsp_data;
            got.part_last      = rsp_part_last;
            got.packet_last    = rsp_packet_last;
            got.connack_ok     = rsp_connack_ok;
            got.send_subscribe = rsp_send_subscribe;
            check_result(got);
            results_seen++;
            kind_count[rsp_kind]++;
            if (rsp_send_subscribe) subscribe_seen++;
         end
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, deframed_results.size());
         $display("mqtt_receive_deframer test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, directed packets, then three random phases with
   // different idling mixes. Between phases, pause the sender until every
   // outstanding result has been delivered.
   // ------------------------------------------------------------------------
   initial begin
      clear_session();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed corner packets
      add_restart();
      add_connack(0, 1'b0);                          // empty connack: not ok
      add_connack(2, 1'b1);                          // first success: subscribe
      add_publish(16'h0001, 1);                      // topic only, empty payload
      add_packet({TYPE_PUBLISH, 4'hF}, 1);           // short publish, all flags
      add_publish(16'h0000, 1);                      // zero topic length
      add_unterminated();                            // length never terminates

      // Sender idles rarely, receiver often
      send_idle_pct = 22;
      recv_idle_pct = 74;
      add_random_traffic(400);
      while (rx_backlog.size() != 0 || deframed_results.size() != 0) @(posedge clock);

      // Swap the idling mix
      send_idle_pct = 74;
      recv_idle_pct = 22;
      add_random_traffic(400);
      while (rx_backlog.size() != 0 || deframed_results.size() != 0) @(posedge clock);

      // Full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_traffic(400);
      while (rx_backlog.size() != 0 || deframed_results.size() != 0) @(posedge clock);

      // Let any stray result surface
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (deframed_results.size() != 0)
         report($sformatf("%0d results never arrived", deframed_results.size()));

      $display("Run covered %0d input bytes (%0d link restarts) and %0d results:",
               bytes_sent, restarts_sent, results_seen);
      $display("  %0d topic, %0d payload, %0d connack (%0d subscribe), %0d framing errors",
               kind_count[KIND_TOPIC], kind_count[KIND_PAYLOAD], kind_count[KIND_VERDICT],
               subscribe_seen, kind_count[KIND_ERROR]);
      if (mismatches == 0) begin
         $display("mqtt_receive_deframer test passed");
      end else begin
         $display("mqtt_receive_deframer test failed");
      end
      $finish;
   end

endmodule
